>>> rtl/lapedge_pkg.sv
// Shared types and constants for the Laplacian edge threshold block.
`default_nettype none

package lapedge_pkg;

    // Channel and pixel layout: index 2 red, 1 green, 0 blue
    localparam int CHAN_W = 8;
    localparam int NUM_CHAN = 3;
    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [NUM_CHAN-1:0] pixel_t;

    localparam int CH_RED = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE = 0;

    // Configuration register widths
    localparam int FW_W = 11;
    localparam int FH_W = 13;
    localparam int THR_W = 8;

    // Row counters and height limits
    localparam int IN_ROW_W = 13;
    localparam int OUT_ROW_W = 12;
    localparam logic [IN_ROW_W-1:0] IN_ROW_SAT = 13'd8191;
    localparam logic [FH_W-1:0] HEIGHT_MAX = 13'd4096;

    // Defaults after reset
    localparam int MAX_WIDTH_DEF = 1024;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = 8'd6;

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

    // Edge mark values
    localparam chan_t MARK_ON = 8'hFF;
    localparam chan_t MARK_OFF = 8'h00;

    // Border flags for the output position
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic first_col;
        logic last_col;
    } border_t;

endpackage

`default_nettype wire

>>> rtl/lapedge_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lapedge_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read old contents first, then write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/lapedge_kernel.sv
// 3x3 Laplacian with border replication and threshold marking per channel.
`default_nettype none

module lapedge_kernel (
    input  wire lapedge_pkg::pixel_t [2:0][2:0] win,
    input  wire lapedge_pkg::border_t           border,
    input  wire logic [lapedge_pkg::THR_W-1:0]  threshold,
    output lapedge_pkg::chan_t                  edge_red,
    output lapedge_pkg::chan_t                  edge_green,
    output lapedge_pkg::chan_t                  edge_blue
);

    logic [1:0] rsel [3];
    logic [1:0] csel [3];
    lapedge_pkg::pixel_t [2:0][2:0] tap;
    lapedge_pkg::chan_t mark [lapedge_pkg::NUM_CHAN];

    // Replace taps outside the frame by the centre row or column
    always_comb
    begin
        rsel[0] = border.first_row ? 2'd1 : 2'd0;
        rsel[1] = 2'd1;
        rsel[2] = border.last_row ? 2'd1 : 2'd2;
        csel[0] = border.first_col ? 2'd1 : 2'd0;
        csel[1] = 2'd1;
        csel[2] = border.last_col ? 2'd1 : 2'd2;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                tap[r][c] = win[rsel[r]][csel[c]];
            end
        end
    end

    // Eight times centre less the neighbours, magnitude over 8, compare
    always_comb
    begin
        logic [10:0] nsum;
        logic [10:0] cen8;
        logic signed [11:0] diff;
        logic [11:0] mag;
        for (int ch = 0; ch < lapedge_pkg::NUM_CHAN; ch++)
        begin
            nsum = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (!(r == 1 && c == 1))
                    begin
                        nsum = nsum + 11'(tap[r][c][ch]);
                    end
                end
            end
            cen8 = {tap[1][1][ch], 3'b000};
            diff = $signed({1'b0, cen8}) - $signed({1'b0, nsum});
            mag = diff[11] ? 12'(-diff) : 12'(diff);
            mark[ch] = (mag[10:3] > threshold) ? lapedge_pkg::MARK_ON
                                                : lapedge_pkg::MARK_OFF;
        end
    end

    assign edge_red = mark[lapedge_pkg::CH_RED];
    assign edge_green = mark[lapedge_pkg::CH_GREEN];
    assign edge_blue = mark[lapedge_pkg::CH_BLUE];

endmodule

`default_nettype wire

>>> rtl/laplacian_edge_threshold.sv
// Top level of the streaming 3x3 Laplacian edge threshold block for RGB frames.
// Input words carry one pixel each in raster order (in_valid/in_ready); after the
// last pixel of a frame the source sends frame_width+1 filler words to flush it.
// Output words (out_valid/out_ready) carry the red, green and blue edge marks and frame_end.
// The first frame_width+1 words of a frame give no output; every later word gives
// the result for the pixel frame_width+1 words earlier, registered in the output
// register when that word leaves the RAM-read stage. Throughput is one word per
// clock while out_ready holds: each word reads both line RAMs once at its column
// and writes them back once when it leaves the RAM-read stage. Configuration goes
// through the APB port (frame_width at 0x0, frame_height at 0x4, edge_threshold
// at 0x8); the user writes it only while idle (the block does not enforce it).
// Reset loads 640, 480 and 6 into the registers, clears the counters, the window
// and both pipeline stages; the line RAMs are not cleared, as every tap read
// from a stale entry falls outside the frame and is replaced.
// When the receiver stalls the output register holds its word; the block still
// takes input while the RAM-read stage can drain, and drops in_ready once that
// stage holds a word with a result that cannot move on.
`default_nettype none

module laplacian_edge_threshold #(
    parameter int MAX_WIDTH = lapedge_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lapedge_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [lapedge_pkg::PDATA_W-1:0]    pwdata,
    output logic      [lapedge_pkg::PDATA_W-1:0]    prdata,
    output logic                                    pready,
    // Pixel input
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire lapedge_pkg::chan_t                 pixel_red,
    input  wire lapedge_pkg::chan_t                 pixel_green,
    input  wire lapedge_pkg::chan_t                 pixel_blue,
    input  wire logic                               is_filler,
    // Edge output
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output lapedge_pkg::chan_t                      edge_red,
    output lapedge_pkg::chan_t                      edge_green,
    output lapedge_pkg::chan_t                      edge_blue,
    output logic                                    frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    // Configuration registers
    logic [lapedge_pkg::FW_W-1:0]  frame_width_reg;
    logic [lapedge_pkg::FH_W-1:0]  frame_height_reg;
    logic [lapedge_pkg::THR_W-1:0] edge_threshold_reg;
    logic                          cfg_write;

    // Position counters
    logic [COL_W-1:0]                  in_col_reg, in_col_next;
    logic [lapedge_pkg::IN_ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]                  out_col_reg, out_col_next;
    logic [lapedge_pkg::OUT_ROW_W-1:0] out_row_reg, out_row_next;

    logic [WID_W-1:0]             eff_w;
    logic [lapedge_pkg::FH_W-1:0] eff_h;
    logic                         in_accept;
    logic                         res_now;
    logic                         in_last_col;
    lapedge_pkg::border_t         border_now;
    logic                         fend_now;
    lapedge_pkg::pixel_t          px_now;

    // RAM-read stage
    logic                 s1_v_reg;
    lapedge_pkg::pixel_t  s1_px_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic                 s1_res_reg;
    logic                 s1_fend_reg;
    lapedge_pkg::border_t s1_border_reg;
    logic                 s1_fwd_reg;
    lapedge_pkg::pixel_t  s1_fwd_top_reg;
    lapedge_pkg::pixel_t  s1_fwd_mid_reg;
    logic                 s1_adv;
    lapedge_pkg::pixel_t  up_rdata;
    lapedge_pkg::pixel_t  mid_rdata;
    lapedge_pkg::pixel_t  top_eff;
    lapedge_pkg::pixel_t  mid_eff;

    // Window and output stage
    lapedge_pkg::pixel_t [2:0][2:0] win_reg, win_next;
    lapedge_pkg::chan_t  mark_red, mark_green, mark_blue;
    logic                out_valid_reg;
    lapedge_pkg::chan_t  edge_red_reg, edge_green_reg, edge_blue_reg;
    logic                frame_end_reg;

    // APB writes and reads
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= lapedge_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= lapedge_pkg::FRAME_HEIGHT_RST;
            edge_threshold_reg <= lapedge_pkg::EDGE_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                lapedge_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= pwdata[lapedge_pkg::FW_W-1:0];
                lapedge_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[lapedge_pkg::FH_W-1:0];
                lapedge_pkg::REG_EDGE_THRESHOLD:
                    edge_threshold_reg <= pwdata[lapedge_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            lapedge_pkg::REG_FRAME_WIDTH:
                prdata = lapedge_pkg::PDATA_W'(frame_width_reg);
            lapedge_pkg::REG_FRAME_HEIGHT:
                prdata = lapedge_pkg::PDATA_W'(frame_height_reg);
            lapedge_pkg::REG_EDGE_THRESHOLD:
                prdata = lapedge_pkg::PDATA_W'(edge_threshold_reg);
            default:
                prdata = '0;
        endcase
    end

    // Clamp width and height into their working ranges
    always_comb
    begin
        if (frame_width_reg == '0)
            eff_w = WID_W'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            eff_w = WID_W'(MAX_WIDTH);
        else
            eff_w = WID_W'(frame_width_reg);

        if (frame_height_reg == '0)
            eff_h = lapedge_pkg::FH_W'(1);
        else if (frame_height_reg > lapedge_pkg::HEIGHT_MAX)
            eff_h = lapedge_pkg::HEIGHT_MAX;
        else
            eff_h = frame_height_reg;
    end

    // Decide position, result and border for the word at the input
    assign in_accept = in_valid && in_ready;
    assign res_now = (in_row_reg >= lapedge_pkg::IN_ROW_W'(2))
                  || (in_row_reg == lapedge_pkg::IN_ROW_W'(1) && in_col_reg != '0);
    assign in_last_col = (WID_W'(in_col_reg) + WID_W'(1)) >= eff_w;
    assign border_now.first_row = (out_row_reg == '0);
    assign border_now.last_row =
        (lapedge_pkg::FH_W'(out_row_reg) + lapedge_pkg::FH_W'(1)) >= eff_h;
    assign border_now.first_col = (out_col_reg == '0);
    assign border_now.last_col = (WID_W'(out_col_reg) + WID_W'(1)) >= eff_w;
    assign fend_now = res_now && border_now.last_row && border_now.last_col;

    always_comb
    begin
        if (is_filler)
            px_now = '0;
        else
        begin
            px_now[lapedge_pkg::CH_RED] = pixel_red;
            px_now[lapedge_pkg::CH_GREEN] = pixel_green;
            px_now[lapedge_pkg::CH_BLUE] = pixel_blue;
        end
    end

    // Advance the counters; the last output of a frame clears them all
    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (fend_now)
        begin
            in_col_next = '0;
            in_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else
        begin
            if (res_now)
            begin
                if (border_now.last_col)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + lapedge_pkg::OUT_ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            if (in_last_col)
            begin
                in_col_next = '0;
                if (in_row_reg != lapedge_pkg::IN_ROW_SAT)
                    in_row_next = in_row_reg + lapedge_pkg::IN_ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (in_accept)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Line buffers: upper takes the old middle entry, middle takes the pixel
    lapedge_ram #(
        .WIDTH (lapedge_pkg::NUM_CHAN * lapedge_pkg::CHAN_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (mid_eff),
        .re    (in_accept),
        .raddr (in_col_reg),
        .rdata (up_rdata)
    );

    lapedge_ram #(
        .WIDTH (lapedge_pkg::NUM_CHAN * lapedge_pkg::CHAN_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_px_reg),
        .re    (in_accept),
        .raddr (in_col_reg),
        .rdata (mid_rdata)
    );

    // Take the pending write instead of the RAM when the column repeats
    assign top_eff = s1_fwd_reg ? s1_fwd_top_reg : up_rdata;
    assign mid_eff = s1_fwd_reg ? s1_fwd_mid_reg : mid_rdata;

    // Stage flow: a word without a result never waits for the output register
    assign s1_adv = s1_v_reg && (!s1_res_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_v_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (in_accept)
            s1_v_reg <= 1'b1;
        else if (s1_adv)
            s1_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_px_reg <= px_now;
            s1_col_reg <= in_col_reg;
            s1_res_reg <= res_now;
            s1_fend_reg <= fend_now;
            s1_border_reg <= border_now;
            s1_fwd_reg <= s1_v_reg && (s1_col_reg == in_col_reg);
            s1_fwd_top_reg <= mid_eff;
            s1_fwd_mid_reg <= s1_px_reg;
        end
    end

    // Shift the window one column and bring in the new column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = top_eff;
        win_next[1][2] = mid_eff;
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_adv)
            win_reg <= win_next;
    end

    lapedge_kernel u_kernel (
        .win        (win_next),
        .border     (s1_border_reg),
        .threshold  (edge_threshold_reg),
        .edge_red   (mark_red),
        .edge_green (mark_green),
        .edge_blue  (mark_blue)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_res_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_res_reg)
        begin
            edge_red_reg <= mark_red;
            edge_green_reg <= mark_green;
            edge_blue_reg <= mark_blue;
            frame_end_reg <= s1_fend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign edge_red = edge_red_reg;
    assign edge_green = edge_green_reg;
    assign edge_blue = edge_blue_reg;
    assign frame_end = frame_end_reg;

`ifndef SYNTHESIS
    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && fend_now |=> (in_col_reg == '0 && in_row_reg == '0
                                   && out_col_reg == '0 && out_row_reg == '0))
        else $error("counters not cleared after the last word of a frame");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_res_reg |-> (!out_valid_reg || out_ready))
        else $error("result stage advanced over a held output word");

    a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && s1_fwd_reg |-> s1_col_reg == $past(s1_col_reg))
        else $error("line buffer bypass taken for a different column");
`endif

endmodule

`default_nettype wire

>>> bench/edge_checker.sv
// Watches the pixel, edge and configuration ports, predicts every edge word and compares it.
module edge_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [lapedge_pkg::PADDR_W-1:0]   paddr,
    input  logic [lapedge_pkg::PDATA_W-1:0]   pwdata,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  lapedge_pkg::chan_t                pixel_red,
    input  lapedge_pkg::chan_t                pixel_green,
    input  lapedge_pkg::chan_t                pixel_blue,
    input  logic                              is_filler,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  lapedge_pkg::chan_t                edge_red,
    input  lapedge_pkg::chan_t                edge_green,
    input  lapedge_pkg::chan_t                edge_blue,
    input  logic                              frame_end,
    output int                                n_pending,
    output int                                n_errors,
    output logic                              at_frame_start
);

    typedef struct packed {
        lapedge_pkg::chan_t red;
        lapedge_pkg::chan_t green;
        lapedge_pkg::chan_t blue;
        logic               last;
    } mark_word_t;

    // Shadow of the configuration registers
    logic [lapedge_pkg::FW_W-1:0]  width_reg;
    logic [lapedge_pkg::FH_W-1:0]  height_reg;
    logic [lapedge_pkg::THR_W-1:0] thr_reg;

    // Shadow of the line stores, the 3x3 window and the position counters
    lapedge_pkg::pixel_t upper_row [lapedge_pkg::MAX_WIDTH_DEF];
    lapedge_pkg::pixel_t middle_row [lapedge_pkg::MAX_WIDTH_DEF];
    lapedge_pkg::pixel_t win [3][3];
    int unsigned         col_in;
    int unsigned         row_in;
    int unsigned         col_out;
    int unsigned         row_out;

    mark_word_t  expected_marks [$];
    int          n_results;

    // Scale the magnitude down by eight and compare with the threshold
    function automatic lapedge_pkg::chan_t edge_mark(input int acc);
        int unsigned mag;
        mag = (acc < 0) ? -acc : acc;
        return (mag / 8 > thr_reg) ? lapedge_pkg::MARK_ON : lapedge_pkg::MARK_OFF;
    endfunction

    // Shift one pixel word through the lines and window; queue its edge word if one is due
    task automatic run_laplacian();
        int unsigned         w;
        int unsigned         h;
        int unsigned         col;
        int                  sr;
        int                  sc;
        int                  acc [lapedge_pkg::NUM_CHAN];
        logic                last_r;
        logic                last_c;
        lapedge_pkg::pixel_t px;
        lapedge_pkg::pixel_t top_px;
        lapedge_pkg::pixel_t mid_px;
        lapedge_pkg::pixel_t tap;
        mark_word_t          mw;

        w = (width_reg == 0) ? 1
          : ((width_reg > lapedge_pkg::MAX_WIDTH_DEF) ? lapedge_pkg::MAX_WIDTH_DEF : width_reg);
        h = (height_reg == 0) ? 1
          : ((height_reg > lapedge_pkg::HEIGHT_MAX) ? lapedge_pkg::HEIGHT_MAX : height_reg);

        px[lapedge_pkg::CH_RED] = pixel_red;
        px[lapedge_pkg::CH_GREEN] = pixel_green;
        px[lapedge_pkg::CH_BLUE] = pixel_blue;
        if (is_filler)
            px = '0;

        // read both lines at this column, then push the column down by one line
        col = (col_in < lapedge_pkg::MAX_WIDTH_DEF) ? col_in : 0;
        top_px = upper_row[col];
        mid_px = middle_row[col];
        upper_row[col] = mid_px;
        middle_row[col] = px;

        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top_px;
        win[1][2] = mid_px;
        win[2][2] = px;

        if (row_in >= 2 || (row_in == 1 && col_in >= 1))
        begin
            last_r = (row_out + 1 >= h);
            last_c = (col_out + 1 >= w);
            acc = '{0, 0, 0};
            // replicate the border: taps outside the frame take the centre row or column
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sr = r;
                    if (r == 0 && row_out == 0)
                        sr = 1;
                    if (r == 2 && last_r)
                        sr = 1;
                    sc = c;
                    if (c == 0 && col_out == 0)
                        sc = 1;
                    if (c == 2 && last_c)
                        sc = 1;
                    tap = win[sr][sc];
                    for (int k = 0; k < lapedge_pkg::NUM_CHAN; k++)
                        acc[k] += (r == 1 && c == 1) ? 8 * int'(tap[k]) : -int'(tap[k]);
                end
            end
            mw.red = edge_mark(acc[lapedge_pkg::CH_RED]);
            mw.green = edge_mark(acc[lapedge_pkg::CH_GREEN]);
            mw.blue = edge_mark(acc[lapedge_pkg::CH_BLUE]);
            mw.last = last_r && last_c;
            expected_marks.push_back(mw);

            // the last edge word of a frame restarts every counter
            if (mw.last)
            begin
                col_in = 0;
                row_in = 0;
                col_out = 0;
                row_out = 0;
                return;
            end
            if (last_c)
            begin
                col_out = 0;
                row_out++;
            end
            else
                col_out++;
        end

        if (col_in + 1 >= w)
        begin
            col_in = 0;
            if (row_in < lapedge_pkg::IN_ROW_SAT)
                row_in++;
        end
        else
            col_in++;
    endtask

    // Sample at the falling edge: a handshake seen here completes at the next rising edge
    always @(negedge clk)
    begin : watch
        mark_word_t want;
        if (!rst_n)
        begin
            width_reg = lapedge_pkg::FRAME_WIDTH_RST;
            height_reg = lapedge_pkg::FRAME_HEIGHT_RST;
            thr_reg = lapedge_pkg::EDGE_THRESHOLD_RST;
            for (int i = 0; i < lapedge_pkg::MAX_WIDTH_DEF; i++)
            begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            col_in = 0;
            row_in = 0;
            col_out = 0;
            row_out = 0;
            expected_marks.delete();
            n_errors = 0;
            n_results = 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                case (paddr[lapedge_pkg::PADDR_W-1:2])
                    lapedge_pkg::REG_FRAME_WIDTH:
                        width_reg = pwdata[lapedge_pkg::FW_W-1:0];
                    lapedge_pkg::REG_FRAME_HEIGHT:
                        height_reg = pwdata[lapedge_pkg::FH_W-1:0];
                    lapedge_pkg::REG_EDGE_THRESHOLD:
                        thr_reg = pwdata[lapedge_pkg::THR_W-1:0];
                    default: ;
                endcase
            end

            // compare an accepted edge word with the oldest prediction
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_marks.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("edge word %0d with none expected: r=%0d g=%0d b=%0d e=%0b",
                                 n_results, edge_red, edge_green, edge_blue, frame_end);
                end
                else
                begin
                    want = expected_marks.pop_front();
                    if (edge_red !== want.red || edge_green !== want.green ||
                        edge_blue !== want.blue || frame_end !== want.last)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                        begin
                            $write("edge word %0d: expected r=%0d g=%0d b=%0d end=%0b, ",
                                   n_results, want.red, want.green, want.blue, want.last);
                            $display("got r=%0d g=%0d b=%0d end=%0b",
                                     edge_red, edge_green, edge_blue, frame_end);
                        end
                    end
                end
            end

            if (in_valid && in_ready)
                run_laplacian();
        end
        n_pending = expected_marks.size();
        at_frame_start = (col_in == 0 && row_in == 0);
    end

endmodule

>>> bench/tb_top.sv
// Testbench top: drives frames and register writes into the edge block and reports the verdict.
module tb_top;

    localparam int LIMIT = 1_000_000;
    localparam int SETTLE = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 1300;
    localparam int TAIL_WORDS = 250;

    typedef enum int {TEX_NOISE, TEX_FLAT, TEX_STEP} texture_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [lapedge_pkg::PADDR_W-1:0] paddr = '0;
    logic [lapedge_pkg::PDATA_W-1:0] pwdata = '0;
    logic [lapedge_pkg::PDATA_W-1:0] prdata;
    logic                            pready;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    lapedge_pkg::chan_t              pixel_red = '0;
    lapedge_pkg::chan_t              pixel_green = '0;
    lapedge_pkg::chan_t              pixel_blue = '0;
    logic                            is_filler = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    lapedge_pkg::chan_t              edge_red;
    lapedge_pkg::chan_t              edge_green;
    lapedge_pkg::chan_t              edge_blue;
    logic                            frame_end;

    int                 n_pending;
    int                 n_errors;
    logic               at_frame_start;

    bit                 src_gaps = 1'b0;
    bit                 sink_gaps = 1'b0;
    bit                 hold_long = 1'b0;
    int                 eff_w = 1;
    int                 eff_h = 1;
    int                 words_sent = 0;
    int                 cycle_count = 0;

    laplacian_edge_threshold u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
        .is_filler(is_filler),
        .out_valid(out_valid), .out_ready(out_ready),
        .edge_red(edge_red), .edge_green(edge_green), .edge_blue(edge_blue),
        .frame_end(frame_end)
    );

    edge_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
        .is_filler(is_filler),
        .out_valid(out_valid), .out_ready(out_ready),
        .edge_red(edge_red), .edge_green(edge_green), .edge_blue(edge_blue),
        .frame_end(frame_end),
        .n_pending(n_pending), .n_errors(n_errors), .at_frame_start(at_frame_start)
    );

    always #6 clk = ~clk;

    // Abandon the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Edge word sink: random stalls, plus one long hold-off on request
    initial
    begin : sink
        int stall;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
                out_ready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 14);
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic lapedge_pkg::chan_t any_chan();
        return lapedge_pkg::chan_t'($urandom_range(0, 255));
    endfunction

    // Pixel value for one channel at column x of a frame with the given texture
    function automatic lapedge_pkg::chan_t shade(input texture_t tex, input int x, input int w,
                                                 input int base, input int alt);
        case (tex)
            TEX_NOISE: return lapedge_pkg::chan_t'($urandom_range(0, 255));
            TEX_FLAT:  return lapedge_pkg::chan_t'(base + $urandom_range(0, 6));
            default:   return lapedge_pkg::chan_t'(((2 * x < w) ? base : alt)
                                                   + $urandom_range(0, 6));
        endcase
    endfunction

    // Offer one pixel word, with an optional gap first, and hold it until taken
    task automatic send_word(input lapedge_pkg::chan_t r, input lapedge_pkg::chan_t g,
                             input lapedge_pkg::chan_t b, input logic fill);
        if (src_gaps && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_red <= r;
        pixel_green <= g;
        pixel_blue <= b;
        is_filler <= fill;
        @(negedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and wait until every edge word is in and the pipeline has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (n_pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Write the geometry (and the threshold unless negative) once the block is idle
    task automatic reconfigure(input int w, input int h, input int thr);
        settle();
        apb_write(lapedge_pkg::REG_FRAME_WIDTH, w);
        apb_write(lapedge_pkg::REG_FRAME_HEIGHT, h);
        if (thr >= 0)
            apb_write(lapedge_pkg::REG_EDGE_THRESHOLD, thr);
        eff_w = (w == 0) ? 1
              : ((w > lapedge_pkg::MAX_WIDTH_DEF) ? lapedge_pkg::MAX_WIDTH_DEF : w);
        eff_h = (h == 0) ? 1 : ((h > lapedge_pkg::HEIGHT_MAX) ? lapedge_pkg::HEIGHT_MAX : h);
    endtask

    // One frame in raster order, then the flush words (cut short when broken)
    task automatic send_frame(input int w, input int h, input texture_t tex, input bit broken);
        int                 base [3];
        int                 alt [3];
        int                 n_fill;
        lapedge_pkg::chan_t px [3];
        for (int k = 0; k < 3; k++)
        begin
            base[k] = $urandom_range(0, 249);
            alt[k] = $urandom_range(0, 249);
        end
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                for (int k = 0; k < 3; k++)
                    px[k] = shade(tex, x, w, base[k], alt[k]);
                send_word(px[2], px[1], px[0], $urandom_range(0, 39) == 0);
            end
        end
        n_fill = broken ? $urandom_range(0, w) : w + 1;
        repeat (n_fill) send_word(any_chan(), any_chan(), any_chan(), 1'b1);
    endtask

    // Flush until the block is back at the start of a frame
    task automatic close_frame();
        while (!at_frame_start)
            send_word(any_chan(), any_chan(), any_chan(), 1'b1);
    endtask

    initial
    begin : stimulus
        logic [23:0] probe_3x3 [9];
        logic [23:0] corner_2x2 [4];
        int          phase;
        int          directed_words;

        probe_3x3 = '{24'h000000, 24'hFF0080, 24'h000000,
                      24'h00FF01, 24'hFFFFFF, 24'h00FE00,
                      24'hFF0000, 24'h0080FF, 24'hFFFFFF};
        corner_2x2 = '{24'h000000, 24'hFFFFFF, 24'h010203, 24'hFEFDFC};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame of extreme values at the reset threshold; flush words carry junk
        reconfigure(3, 3, -1);
        foreach (probe_3x3[i])
            send_word(probe_3x3[i][23:16], probe_3x3[i][15:8], probe_3x3[i][7:0], 1'b0);
        repeat (4) send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);

        // zero width and height act as a single pixel; top threshold marks nothing
        reconfigure(0, 0, 255);
        send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
        repeat (2) send_word(8'h00, 8'h00, 8'h00, 1'b1);

        // 2x2 frame, every window touches the border, threshold zero
        reconfigure(2, 2, 0);
        foreach (corner_2x2[i])
            send_word(corner_2x2[i][23:16], corner_2x2[i][15:8], corner_2x2[i][7:0], 1'b0);
        send_word(8'hFF, 8'h00, 8'hFF, 1'b1);
        repeat (2) send_word(8'h00, 8'h00, 8'h00, 1'b1);

        // random geometry and threshold per phase, a few frames each; no idling at the end
        directed_words = words_sent;
        phase = 0;
        while (words_sent - directed_words < RANDOM_WORDS)
        begin
            if (words_sent - directed_words < RANDOM_WORDS - TAIL_WORDS)
            begin
                src_gaps = ($urandom_range(0, 3) != 0);
                sink_gaps = ($urandom_range(0, 3) != 0);
            end
            else
            begin
                src_gaps = 1'b0;
                sink_gaps = 1'b0;
            end
            reconfigure(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12),
                        ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 40));
            if (phase == 3)
                hold_long = 1'b1;
            if (phase == 6)
            begin
                // stop inside a frame and change the geometry under it
                repeat ($urandom_range(4, 3 * eff_w + 4))
                    send_word(any_chan(), any_chan(), any_chan(), 1'b0);
                reconfigure($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 40));
            end
            repeat ($urandom_range(1, 4))
                send_frame(eff_w, eff_h, texture_t'($urandom_range(0, 2)),
                           $urandom_range(0, 9) == 0);
            close_frame();
            phase++;
        end

        settle();
        repeat (12) @(posedge clk);
        if (n_errors == 0 && n_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> laplacian_edge_threshold.f
rtl/lapedge_pkg.sv
rtl/lapedge_ram.sv
rtl/lapedge_kernel.sv
rtl/laplacian_edge_threshold.sv
bench/edge_checker.sv
bench/tb_top.sv
